// ===== rtl/kpt_pkg.sv =====
package kpt_pkg;

  localparam int KPT_CAPACITY = 256;
  localparam int KEY_W = 44;
  localparam int PRICE_W = 27;
  localparam int POS_W = 8;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_DELETE  = 2'd2,
    OP_READ_AT = 2'd3
  } kpt_op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } kpt_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } kpt_state_t;

  typedef struct packed {
    kpt_op_t              operation;
    logic [KEY_W-1:0]     key_code;
    logic [PRICE_W-1:0]   price_cents;
    logic [POS_W-1:0]     position;
  } kpt_in_t;

  typedef struct packed {
    kpt_status_t          status;
    logic [PRICE_W-1:0]   found_price;
    logic [KEY_W-1:0]     found_key;
    logic [COUNT_W-1:0]   entry_count;
  } kpt_out_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic                 load;
    logic                 read_at;
    logic [KEY_W-1:0]     cmp_key;
    logic                 exec_wr;
    logic                 exec_del;
    logic [KEY_W-1:0]     wr_key;
    logic [PRICE_W-1:0]   wr_price;
  } kpt_cell_ctl_t;

endpackage

// ===== rtl/keyed_price_table.sv =====
// each transaction is compared in the cell row at accept, then executed in S_EXEC, which loads the result register
// a new transaction is taken only once the last one has executed; execute waits while the result register is stalled
// the execute cycle resolves the cell row's match vector and does a one-step shift on delete
// reset: entry count cleared and the controller returns to idle; cell contents are not cleared
module keyed_price_table
  import kpt_pkg::*;
#(
  parameter int CAPACITY = KPT_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kpt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kpt_out_t out_data
);

  // count must hold CAPACITY itself
  localparam int CW = $clog2(CAPACITY + 1);
  // width used to compare position against a cell index
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = (IW > POS_W) ? IW : POS_W;

  kpt_state_t      state_r, state_nxt;
  kpt_in_t         item_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  kpt_out_t        out_data_r, out_data_nxt;

  kpt_cell_ctl_t   ctl;
  logic            accept;
  logic            fire;
  logic            full;
  logic [PW-1:0]   pos_ext;

  logic [CAPACITY-1:0]  pick;
  logic [CAPACITY:0]    seen;
  logic [KEY_W-1:0]     cell_key   [CAPACITY];
  logic [PRICE_W-1:0]   cell_price [CAPACITY];

  logic                 hit_any;
  logic [KEY_W-1:0]     hit_key;
  logic [PRICE_W-1:0]   hit_price;
  logic [CW+COUNT_W-1:0] count_ext;

  // handshake: one transaction in flight, the result register decouples the output side
  assign accept   = in_valid & ~in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fire     = (state_r == S_EXEC) & ~(out_valid_r & out_stall);
  assign full     = (count_r == CW'(CAPACITY));
  assign pos_ext  = PW'(in_data.position);

  // broadcast to the cell row: compare at accept, update at execute
  always_comb begin
    ctl.load     = accept;
    ctl.read_at  = (in_data.operation == OP_READ_AT);
    ctl.cmp_key  = in_data.key_code;
    ctl.exec_wr  = fire & (item_r.operation == OP_INSERT) & ~hit_any & ~full;
    ctl.exec_del = fire & (item_r.operation == OP_DELETE) & hit_any;
    ctl.wr_key   = item_r.key_code;
    ctl.wr_price = item_r.price_cents;
  end

  assign seen[0] = 1'b0;

  // row of cells, entry i lives in cell i, deletes pull from the right neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic live, pos_sel, tail;
    logic [KEY_W-1:0]   nb_key;
    logic [PRICE_W-1:0] nb_price;

    assign live    = (count_r > CW'(i));
    assign tail    = (count_r == CW'(i));
    assign pos_sel = (pos_ext == PW'(i));

    if (i == CAPACITY - 1) begin : g_last
      assign nb_key   = cell_key[i];
      assign nb_price = cell_price[i];
    end else begin : g_mid
      assign nb_key   = cell_key[i+1];
      assign nb_price = cell_price[i+1];
    end

    kpt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .live     (live),
      .pos_sel  (pos_sel),
      .tail     (tail),
      .seen_in  (seen[i]),
      .nb_key   (nb_key),
      .nb_price (nb_price),
      .seen_out (seen[i+1]),
      .pick_q   (pick[i]),
      .key_q    (cell_key[i]),
      .price_q  (cell_price[i])
    );
  end

  // keys are unique among live entries, so at most one cell picks and and-or is enough
  always_comb begin
    hit_any   = 1'b0;
    hit_key   = '0;
    hit_price = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_any = hit_any | pick[i];
      if (pick[i]) begin
        hit_key   = hit_key | cell_key[i];
        hit_price = hit_price | cell_price[i];
      end
    end
  end

  // controller and result register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    count_ext     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt                = S_IDLE;
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.found_price = '0;
          out_data_nxt.found_key   = '0;
          case (item_r.operation)
            OP_INSERT: begin
              if (hit_any) begin
                out_data_nxt.status = ST_DUPLICATE;
              end else if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            OP_LOOKUP: begin
              if (hit_any) begin
                out_data_nxt.found_price = hit_price;
              end else begin
                out_data_nxt.status = ST_NOT_FOUND;
              end
            end
            OP_DELETE: begin
              if (hit_any) begin
                count_nxt = count_r - CW'(1);
              end else begin
                out_data_nxt.status = ST_NOT_FOUND;
              end
            end
            OP_READ_AT: begin
              if (hit_any) begin
                out_data_nxt.found_price = hit_price;
                out_data_nxt.found_key   = hit_key;
              end else begin
                out_data_nxt.status = ST_RANGE;
              end
            end
            default: begin
              out_data_nxt.status = ST_OK;
            end
          endcase
          // entry count reports the low bits of the count
          count_ext                = (CW+COUNT_W)'(count_nxt);
          out_data_nxt.entry_count = count_ext[COUNT_W-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // uniqueness of live keys: never more than one cell picks during execute
  a_single_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(pick))
    else $error("more than one cell matched");

  // the count only changes on an execute cycle that hands over a result
  a_count_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> $past(fire))
    else $error("entry count changed outside execute");

  // an execute cycle that fires always loads the result register
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("execute without a result");

endmodule

// ===== rtl/kpt_cell.sv =====
module kpt_cell
  import kpt_pkg::*;
(
  input  logic                clk,
  input  kpt_cell_ctl_t       ctl,
  input  logic                live,
  input  logic                pos_sel,
  input  logic                tail,
  input  logic                seen_in,
  input  logic [KEY_W-1:0]    nb_key,
  input  logic [PRICE_W-1:0]  nb_price,
  output logic                seen_out,
  output logic                pick_q,
  output logic [KEY_W-1:0]    key_q,
  output logic [PRICE_W-1:0]  price_q
);

  logic [KEY_W-1:0]   key_r;
  logic [PRICE_W-1:0] price_r;
  logic               pick_r;

  // at or after the deleted entry: take the right neighbor's contents
  assign seen_out = seen_in | pick_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pick_r <= live & (ctl.read_at ? pos_sel : (key_r == ctl.cmp_key));
    end
    if (ctl.exec_wr && tail) begin
      key_r   <= ctl.wr_key;
      price_r <= ctl.wr_price;
    end else if (ctl.exec_del && seen_out) begin
      key_r   <= nb_key;
      price_r <= nb_price;
    end
  end

  assign pick_q  = pick_r;
  assign key_q   = key_r;
  assign price_q = price_r;

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import kpt_pkg::*;

  localparam int QUIET_LIMIT = 3000;      // cycles with no transaction on either side
  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_HOLD = 300;         // receiver back-pressure stretch
  localparam int HOLD_AT_ITEM = 700;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_DEC_MAX = 44'd9999999999999;
  localparam logic [PRICE_W-1:0] PRICE_ALL_ONES = '1;
  localparam logic [PRICE_W-1:0] PRICE_DEC_MAX = 27'd99999999;

  // operation mix of the random part
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_CHURN
  } mix_t;

  // shadow copy of the table; predicts the result of each accepted request
  class price_table_scoreboard;
    logic [KEY_W-1:0]   entry_keys [KPT_CAPACITY];
    logic [PRICE_W-1:0] entry_prices [KPT_CAPACITY];
    int                 entry_total;
    kpt_out_t           pending_replies [$];
    int                 error_count;

    function new();
      entry_total = 0;
      error_count = 0;
    endfunction

    // apply one request to the shadow table and return the reply it earns
    function kpt_out_t apply_request(kpt_in_t req);
      kpt_out_t rsp;
      int hit;
      bit matched;
      rsp = '0;
      rsp.status = ST_OK;
      matched = 1'b0;
      hit = entry_total;
      // first match wins
      for (int i = 0; i < entry_total; i++) begin
        if (!matched && entry_keys[i] == req.key_code) begin
          hit = i;
          matched = 1'b1;
        end
      end
      case (req.operation)
        OP_INSERT: begin
          // duplicate check takes priority over the full check
          if (matched) begin
            rsp.status = ST_DUPLICATE;
          end else if (entry_total >= KPT_CAPACITY) begin
            rsp.status = ST_FULL;
          end else begin
            entry_keys[entry_total] = req.key_code;
            entry_prices[entry_total] = req.price_cents;
            entry_total++;
          end
        end
        OP_LOOKUP: begin
          if (matched) rsp.found_price = entry_prices[hit];
          else rsp.status = ST_NOT_FOUND;
        end
        OP_DELETE: begin
          if (matched) begin
            // later entries move down one slot so insertion order survives
            for (int i = hit; i + 1 < entry_total; i++) begin
              entry_keys[i] = entry_keys[i + 1];
              entry_prices[i] = entry_prices[i + 1];
            end
            entry_total--;
          end else begin
            rsp.status = ST_NOT_FOUND;
          end
        end
        default: begin
          if (int'(req.position) < entry_total) begin
            rsp.found_price = entry_prices[req.position];
            rsp.found_key = entry_keys[req.position];
          end else begin
            rsp.status = ST_RANGE;
          end
        end
      endcase
      rsp.entry_count = COUNT_W'(entry_total);
      return rsp;
    endfunction

    function void note_request(kpt_in_t req);
      kpt_out_t reply;
      reply = apply_request(req);
      pending_replies = {pending_replies, reply};
    endfunction

    function void check_response(kpt_out_t got);
      kpt_out_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d count %0d",
               got.status, got.entry_count);
        error_count++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.found_price !== want.found_price) begin
        $error("found_price mismatch: expected %0d, got %0d",
               want.found_price, got.found_price);
        error_count++;
      end
      if (got.found_key !== want.found_key) begin
        $error("found_key mismatch: expected %0h, got %0h", want.found_key, got.found_key);
        error_count++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count mismatch: expected %0d, got %0d",
               want.entry_count, got.entry_count);
        error_count++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  kpt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kpt_out_t out_data;

  price_table_scoreboard sb;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  keyed_price_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // both channels sampled at the edge, before any update of this step lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_response(out_data);
    end
  end

  // watchdog: a stuck handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: return KEY_W'(raw);                      // raw bits, may exceed 13 digits
      1: return KEY_W'($urandom_range(0, 15));    // narrow pool, collides often
      default: return KEY_W'(raw % 64'd10000000000000);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    if (sb.entry_total == 0) return fresh_key();
    return sb.entry_keys[$urandom_range(0, sb.entry_total - 1)];
  endfunction

  function automatic logic [PRICE_W-1:0] random_price();
    if ($urandom_range(0, 3) == 0) return PRICE_W'($urandom());
    return PRICE_W'($urandom_range(0, 99999999));
  endfunction

  function automatic kpt_in_t make_request(kpt_op_t op, logic [KEY_W-1:0] key,
                                           logic [PRICE_W-1:0] price,
                                           logic [POS_W-1:0] pos);
    kpt_in_t req;
    req.operation = op;
    req.key_code = key;
    req.price_cents = price;
    req.position = pos;
    return req;
  endfunction

  // random request; unused fields are filled too
  function automatic kpt_in_t next_request(mix_t mix);
    kpt_in_t req;
    int roll;
    roll = $urandom_range(0, 99);
    req = make_request(OP_INSERT, fresh_key(), random_price(), POS_W'($urandom()));
    case (mix)
      MIX_GROW: begin
        if (roll < 80) req.operation = OP_INSERT;
        else if (roll < 88) req.operation = OP_LOOKUP;
        else if (roll < 92) req.operation = OP_DELETE;
        else req.operation = OP_READ_AT;
      end
      MIX_SHRINK: begin
        if (roll < 75) req.operation = OP_DELETE;
        else if (roll < 85) req.operation = OP_LOOKUP;
        else if (roll < 90) req.operation = OP_INSERT;
        else req.operation = OP_READ_AT;
      end
      default: req.operation = kpt_op_t'($urandom_range(0, 3));
    endcase
    case (req.operation)
      OP_INSERT: if ($urandom_range(0, 7) == 0) req.key_code = known_key();
      OP_LOOKUP, OP_DELETE: if ($urandom_range(0, 9) != 0) req.key_code = known_key();
      default: begin
        // mostly near the live range, including one past the end
        if (sb.entry_total > 0 && $urandom_range(0, 9) < 7)
          req.position = POS_W'($urandom_range(0, sb.entry_total));
      end
    endcase
    return req;
  endfunction

  task automatic send_item(kpt_in_t req);
    int gap;
    gap = (send_idle && !hold_request) ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_directed();
    // empty table: every miss kind
    send_item(make_request(OP_READ_AT, '0, '0, '0));
    send_item(make_request(OP_LOOKUP, KEY_DEC_MAX, '0, '0));
    send_item(make_request(OP_DELETE, '0, '0, '0));
    // field extremes on insert
    send_item(make_request(OP_INSERT, '0, '0, '0));
    send_item(make_request(OP_INSERT, KEY_ALL_ONES, PRICE_ALL_ONES, '1));
    send_item(make_request(OP_INSERT, KEY_DEC_MAX, PRICE_DEC_MAX, '0));
    send_item(make_request(OP_INSERT, '0, PRICE_DEC_MAX, '0));      // duplicate
    send_item(make_request(OP_LOOKUP, KEY_ALL_ONES, '0, '0));
    send_item(make_request(OP_LOOKUP, '0, '0, '0));
    send_item(make_request(OP_LOOKUP, 44'd1234567890123, '0, '0));  // missing
    send_item(make_request(OP_READ_AT, '0, '0, 8'd0));
    send_item(make_request(OP_READ_AT, '0, '0, 8'd1));
    send_item(make_request(OP_READ_AT, '0, '0, 8'd2));
    send_item(make_request(OP_READ_AT, '0, '0, 8'd3));               // one past the end
    send_item(make_request(OP_READ_AT, '0, '0, '1));
    // delete from the middle, then check the shift
    send_item(make_request(OP_DELETE, KEY_ALL_ONES, '0, '0));
    send_item(make_request(OP_READ_AT, '0, '0, 8'd1));
    send_item(make_request(OP_READ_AT, '0, '0, 8'd2));
    send_item(make_request(OP_DELETE, '0, '0, '0));
    send_item(make_request(OP_DELETE, KEY_ALL_ONES, '0, '0));        // already gone
    send_item(make_request(OP_LOOKUP, KEY_DEC_MAX, '0, '0));
    send_item(make_request(OP_READ_AT, '0, '0, 8'd0));
  endtask

  task automatic run_random();
    mix_t mix;
    int full_tries;
    int churn_left;
    mix = MIX_GROW;
    full_tries = 0;
    churn_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) send_idle = ($urandom_range(0, 3) != 0);
      if (i == HOLD_AT_ITEM) hold_request = 1'b1;
      // fill to capacity, knock on the full table a while, drain, churn, repeat
      case (mix)
        MIX_GROW: begin
          if (sb.entry_total >= KPT_CAPACITY) full_tries++;
          if (full_tries > 24) begin
            mix = MIX_SHRINK;
            full_tries = 0;
          end
        end
        MIX_SHRINK: begin
          if (sb.entry_total == 0) begin
            mix = MIX_CHURN;
            churn_left = 150;
          end
        end
        default: begin
          if (churn_left == 0) mix = MIX_GROW;
          else churn_left--;
        end
      endcase
      send_item(next_request(mix));
    end
  endtask

  // result side: random stalls per transaction, one long hold on request
  initial begin
    int wait_cycles;
    int replies_taken;
    replies_taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end
      if (replies_taken % 50 == 0) recv_idle = ($urandom_range(0, 3) != 0);
      wait_cycles = recv_idle ? $urandom_range(0, 19) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      replies_taken++;
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
